// File: src/assert_macros.svh
// Assertion macros shared by the line-sensor centroid RTL.
// Every macro expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/lsc_pkg.sv
// Package for the line-sensor centroid block: widths, register indexes and
// the item type that travels from the front end through the queue to the back end.
`timescale 1ns / 1ps

package lsc_pkg;

  localparam int MAX_SENSORS = 16;
  localparam int IDX_W       = $clog2(MAX_SENSORS);   // sensor index
  localparam int CNT_W       = IDX_W + 1;             // sensor count, 0..MAX
  localparam int SUM_W       = 7;                     // sum of indexes, up to 120
  localparam int NUM_W       = 12;                    // signed numerator of the mean
  localparam int MAG_W       = NUM_W - 1;             // its magnitude
  localparam int QUO_W       = 7;                     // quotient magnitude, up to 120
  localparam int MEAN_W      = 8;
  localparam int EDGE_W      = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = CNT_W;
  localparam int QDEPTH      = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL = 2'd1;

  localparam logic [CNT_W-1:0] COUNT_RESET = 5'd8;
  localparam logic             LEVEL_RESET = 1'b1;

  // Classified sample as produced by the front end.
  typedef struct packed {
    logic [MAX_SENSORS-1:0]  detect_map;
    logic [CNT_W-1:0]        hits;
    logic [SUM_W-1:0]        idx_sum;
    logic [IDX_W-1:0]        last_idx;     // sensor count minus one
    logic [EDGE_W-1:0]       left_edge;
    logic [EDGE_W-1:0]       right_edge;
  } lsc_item_t;

endpackage

// File: src/lsc_front.sv
// Front end of the line-sensor centroid block: masks and classifies one sample.
// Depends on lsc_pkg.
`timescale 1ns / 1ps

module lsc_front
  import lsc_pkg::*;
(
  input  logic [MAX_SENSORS-1:0] pin_levels,
  input  logic [CNT_W-1:0]       sensor_count,
  input  logic                   active_level,
  output lsc_item_t              item
);

  logic [CNT_W-1:0]       n_eff;
  logic [MAX_SENSORS-1:0] map;
  logic [CNT_W-1:0]       hits;
  logic [SUM_W-1:0]       idx_sum;
  logic [IDX_W-1:0]       lo_idx;
  logic [IDX_W-1:0]       hi_idx;
  logic [IDX_W-1:0]       half;
  logic [MAX_SENSORS-1:0] bit_mask [IDX_W];

  // Counts above the array size saturate.
  assign n_eff = (sensor_count > CNT_W'(MAX_SENSORS)) ? CNT_W'(MAX_SENSORS) : sensor_count;
  assign half  = IDX_W'(n_eff >> 1);

  // A sensor sees the line when it is in use and its pin matches the polarity.
  always_comb begin
    for (int i = 0; i < MAX_SENSORS; i++) begin
      map[i] = (CNT_W'(i) < n_eff) && (pin_levels[i] == active_level);
    end
  end

  assign hits = CNT_W'($countones(map));

  // Sum of detected indexes, one population count per index bit.
  always_comb begin
    idx_sum = '0;
    for (int b = 0; b < IDX_W; b++) begin
      for (int i = 0; i < MAX_SENSORS; i++) begin
        bit_mask[b][i] = map[i] & ((i >> b) % 2 == 1);
      end
      idx_sum = idx_sum + (SUM_W'($countones(bit_mask[b])) << b);
    end
  end

  // Lowest and highest detected index.
  always_comb begin
    lo_idx = '0;
    hi_idx = '0;
    for (int i = MAX_SENSORS - 1; i >= 0; i--) begin
      if (map[i]) lo_idx = IDX_W'(i);
    end
    for (int i = 0; i < MAX_SENSORS; i++) begin
      if (map[i]) hi_idx = IDX_W'(i);
    end
  end

  always_comb begin
    item.detect_map = map;
    item.hits       = hits;
    item.idx_sum    = idx_sum;
    item.last_idx   = IDX_W'(n_eff - CNT_W'(1));
    if (hits != '0) begin
      item.left_edge  = EDGE_W'(lo_idx - half);
      item.right_edge = EDGE_W'(hi_idx - half);
    end else begin
      item.left_edge  = '0;
      item.right_edge = '0;
    end
  end

endmodule

// File: src/lsc_queue.sv
// Short item queue between the front end and the back end of the block.
// Depends on lsc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lsc_queue
  import lsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  lsc_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output lsc_item_t pop_item
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam logic [PTR_W:0]   QFULL    = (PTR_W+1)'(QDEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QDEPTH - 1);

  lsc_item_t        slots [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             push;
  logic             pop;

  assign push_ready = (count != QFULL);
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Item storage.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count <= QFULL, "queue fill count beyond depth")

endmodule

// File: src/lsc_back.sv
// Back end of the line-sensor centroid block: forms the mean numerator and
// divides it by the hit count in a pipelined restoring divider.
// Depends on lsc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lsc_back
  import lsc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  lsc_item_t                item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [MAX_SENSORS-1:0]   detect_map,
  output logic                     line_seen,
  output logic signed [MEAN_W-1:0] mean_offset,
  output logic signed [EDGE_W-1:0] left_edge,
  output logic signed [EDGE_W-1:0] right_edge
);

  // Setup stage plus four divider stages of two quotient bits each, but the last gives one bit.
  localparam int STAGES = 5;

  typedef struct packed {
    logic [MAX_SENSORS-1:0] detect_map;
    logic                   seen;
    logic [EDGE_W-1:0]      left_edge;
    logic [EDGE_W-1:0]      right_edge;
    logic                   neg;
    logic [CNT_W-1:0]       divisor;
    logic [MAG_W-1:0]       rem;
    logic [QUO_W-1:0]       quo;
    logic [MEAN_W-1:0]      mean;
  } stage_t;

  stage_t            st      [STAGES];
  stage_t            st_next [STAGES];
  logic [STAGES-1:0] vld;
  logic              adv;

  // The whole pipe moves unless a finished item waits at the output.
  assign adv      = !vld[STAGES-1] || out_ready;
  assign in_ready = adv;

  // Setup: signed numerator 16*sum - 8*k*(n-1), split into sign and magnitude.
  always_comb begin
    logic [8:0]              prod;
    logic signed [NUM_W-1:0] num;
    prod = 9'(item.hits) * 9'(item.last_idx);
    num  = $signed(NUM_W'({item.idx_sum, 4'b0000})) - $signed(NUM_W'({prod, 3'b000}));
    st_next[0].detect_map = item.detect_map;
    st_next[0].seen       = (item.hits != '0);
    st_next[0].left_edge  = item.left_edge;
    st_next[0].right_edge = item.right_edge;
    st_next[0].neg        = num[NUM_W-1];
    st_next[0].divisor    = item.hits;
    st_next[0].rem        = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
    st_next[0].quo        = '0;
    st_next[0].mean       = '0;
  end

  // Divider stages: quotient bits are produced most significant first.
  for (genvar s = 1; s < STAGES; s++) begin : g_div
    localparam int B0  = QUO_W + 1 - 2 * s;
    localparam int B1  = QUO_W - 2 * s;
    localparam int B1S = (B1 >= 0) ? B1 : 0;

    always_comb begin
      logic [MAG_W:0] dsh;
      stage_t         cur;
      cur = st[s-1];
      if (B0 >= 0) begin
        dsh = (MAG_W+1)'(cur.divisor) << B0;
        if ({1'b0, cur.rem} >= dsh) begin
          cur.rem = cur.rem - MAG_W'(dsh);
          cur.quo = {cur.quo[QUO_W-2:0], 1'b1};
        end else begin
          cur.quo = {cur.quo[QUO_W-2:0], 1'b0};
        end
      end
      if (B1 >= 0) begin
        dsh = (MAG_W+1)'(cur.divisor) << B1S;
        if ({1'b0, cur.rem} >= dsh) begin
          cur.rem = cur.rem - MAG_W'(dsh);
          cur.quo = {cur.quo[QUO_W-2:0], 1'b1};
        end else begin
          cur.quo = {cur.quo[QUO_W-2:0], 1'b0};
        end
      end
      // Signed mean, truncated toward zero; nothing detected gives zero.
      if (!cur.seen) begin
        cur.mean = '0;
      end else if (cur.neg) begin
        cur.mean = MEAN_W'(-{1'b0, cur.quo});
      end else begin
        cur.mean = MEAN_W'({1'b0, cur.quo});
      end
      st_next[s] = cur;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < STAGES; s++) st[s] <= st_next[s];
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  assign out_valid   = vld[STAGES-1];
  assign detect_map  = st[STAGES-1].detect_map;
  assign line_seen   = st[STAGES-1].seen;
  assign mean_offset = $signed(st[STAGES-1].mean);
  assign left_edge   = $signed(st[STAGES-1].left_edge);
  assign right_edge  = $signed(st[STAGES-1].right_edge);

  `ASSERT_IMPLIES(a_stall_holds_input, out_valid && !out_ready, !in_ready, "item taken during stall")
  `ASSERT_IMPLIES(a_empty_result, out_valid && !line_seen, mean_offset == '0 && left_edge == '0 && right_edge == '0, "nonzero result with no detection")

endmodule

// File: src/line_sensor_centroid_top.sv
// Line-sensor centroid: items go from the queue through a setup stage and the divider stages.
// One item per cycle while the output is not stalled, set by the four-stage divider pipeline.
// A stalled output holds the whole back end; the two-entry queue then absorbs input items.
// Reset (synchronous, active high) sets sensor_count to 8 and active_level to 1,
// and empties the queue and the pipeline.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module line_sensor_centroid_top
  import lsc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [MAX_SENSORS-1:0]   pin_levels,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [MAX_SENSORS-1:0]   detect_map,
  output logic                     line_seen,
  output logic signed [MEAN_W-1:0] mean_offset,
  output logic signed [EDGE_W-1:0] left_edge,
  output logic signed [EDGE_W-1:0] right_edge
);

  logic [CNT_W-1:0] sensor_count;
  logic             active_level;
  lsc_item_t        front_item;
  lsc_item_t        head_item;
  logic             head_valid;
  logic             head_ready;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_count <= COUNT_RESET;
      active_level <= LEVEL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SENSOR_COUNT: sensor_count <= cfg_data;
        REG_ACTIVE_LEVEL: active_level <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lsc_front u_front (
    .pin_levels   (pin_levels),
    .sensor_count (sensor_count),
    .active_level (active_level),
    .item         (front_item)
  );

  lsc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (front_item),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_item   (head_item)
  );

  lsc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (head_valid),
    .in_ready    (head_ready),
    .item        (head_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .detect_map  (detect_map),
    .line_seen   (line_seen),
    .mean_offset (mean_offset),
    .left_edge   (left_edge),
    .right_edge  (right_edge)
  );

  `ASSERT_IMPLIES(a_seen_matches_map, out_valid, line_seen == (detect_map != '0), "line flag disagrees with map")

endmodule
